### src/particle_sensor_frame_parser_macros.svh
// Assertion macros shared by the frame parser RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSFP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PSFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser assertion failed");

`endif

### src/psfp_pkg.sv
// Shared types, constants and helper functions for the particle sensor frame parser.
// No dependencies; used by the output skid buffer and the top level.
package psfp_pkg;

	localparam int NUM_READINGS = 12;

	localparam logic [7:0] HEADER_FIRST  = 8'h42;
	localparam logic [7:0] HEADER_SECOND = 8'h4D;
	localparam logic [4:0] POS_LAST      = 5'd31;
	localparam logic [4:0] POS_SUM_END   = 5'd30;
	localparam logic [4:0] POS_FIELD_LO  = 5'd4;
	localparam logic [4:0] POS_FIELD_HI  = 5'd27;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_BAD_HEADER  = 2'd1;
	localparam logic [1:0] STATUS_BAD_SUM     = 2'd2;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

	localparam logic CMD_FRAME_BYTE = 1'b0;
	localparam logic CMD_QUERY      = 1'b1;

	typedef logic [15:0] reading_t;

	typedef struct packed {
		logic [1:0] status;
		reading_t   reading;
		logic       is_frame_result;
	} result_t;

	// Frame order carries the standard values first, then atmospheric, then counts.
	function automatic logic [3:0] field_to_channel(input logic [3:0] field);
		logic [3:0] ch;
		if (field < 4'd3) begin
			ch = field + 4'd3;
		end else if (field < 4'd6) begin
			ch = field - 4'd3;
		end else begin
			ch = field;
		end
		return ch;
	endfunction

endpackage

### src/psfp_skid.sv
// Two-entry output buffer (main register plus skid register) for result items.
// Depends on psfp_pkg for the result_t type.
module psfp_skid import psfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	output result_t out_data,
	input  logic    out_stall
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    take;

	assign take      = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	// Upstream is held off only once the skid slot is occupied, so this is registered.
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_valid_q || take) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || take) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

### src/particle_sensor_frame_parser.sv
// Particle sensor frame parser: one item (frame byte or query) accepted per cycle while
// in_stall is low; each accepted query or last frame byte pushes a registered result
// into the output buffer. The byte add and field capture are combinational, and
// the two-entry output buffer stalls input only when both of its slots are full.
// Reset (arst_n, asynchronous, active low) clears position, sum, pending byte and the
// committed readings, and sets the header flag; the shadow readings are not reset.
`include "particle_sensor_frame_parser_macros.svh"

module particle_sensor_frame_parser import psfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  frame_byte,
	input  logic        frame_start,
	input  logic [3:0]  channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] reading,
	output logic        is_frame_result
);

	logic [4:0]  byte_position_q;
	logic [15:0] running_sum_q;
	logic        header_good_q;
	logic [7:0]  pending_high_byte_q;
	reading_t    shadow_q    [NUM_READINGS];
	reading_t    committed_q [NUM_READINGS];

	logic        in_acc;
	logic        frame_acc;
	logic [4:0]  pos;
	logic [15:0] sum_base;
	logic        hdr_base;
	logic        hdr_next;
	logic [15:0] sum_next;
	logic        in_field;
	logic        take_pending;
	logic        write_shadow;
	logic [3:0]  field_idx;
	logic [3:0]  shadow_idx;
	logic [4:0]  field_off;
	logic [15:0] check;
	logic        at_last;
	logic        commit;
	logic        push;
	result_t     res;
	result_t     out_data;

	assign in_acc    = in_valid && !in_stall;
	assign frame_acc = in_acc && (command == CMD_FRAME_BYTE);

	// A start flag restarts position, sum and header check before this byte is used.
	assign pos      = frame_start ? 5'd0 : byte_position_q;
	assign sum_base = frame_start ? 16'd0 : running_sum_q;
	assign hdr_base = frame_start ? 1'b1 : header_good_q;

	always_comb begin
		hdr_next = hdr_base;
		if (pos == 5'd0 && frame_byte != HEADER_FIRST) begin
			hdr_next = 1'b0;
		end
		if (pos == 5'd1 && frame_byte != HEADER_SECOND) begin
			hdr_next = 1'b0;
		end
	end

	assign sum_next     = (pos < POS_SUM_END) ? sum_base + {8'd0, frame_byte} : sum_base;
	assign in_field     = (pos >= POS_FIELD_LO) && (pos <= POS_FIELD_HI);
	assign take_pending = (in_field && !pos[0]) || (pos == POS_SUM_END);
	assign write_shadow = frame_acc && in_field && pos[0];
	assign field_off    = pos - POS_FIELD_LO;
	assign field_idx    = field_off[4:1];
	assign shadow_idx   = field_to_channel(field_idx);
	assign check        = {pending_high_byte_q, frame_byte};
	assign at_last      = (pos == POS_LAST);
	assign commit       = frame_acc && at_last && hdr_base && (check == sum_base);

	always_comb begin
		res = '0;
		if (command == CMD_QUERY) begin
			res.is_frame_result = 1'b0;
			if (channel < 4'(NUM_READINGS)) begin
				res.status  = STATUS_OK;
				res.reading = committed_q[channel];
			end else begin
				res.status  = STATUS_UNSUPPORTED;
				res.reading = '0;
			end
		end else begin
			res.is_frame_result = 1'b1;
			res.reading         = '0;
			if (!hdr_base) begin
				res.status = STATUS_BAD_HEADER;
			end else if (check != sum_base) begin
				res.status = STATUS_BAD_SUM;
			end else begin
				res.status = STATUS_OK;
			end
		end
	end

	assign push = in_acc && ((command == CMD_QUERY) || at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q     <= '0;
			running_sum_q       <= '0;
			header_good_q       <= 1'b1;
			pending_high_byte_q <= '0;
		end else if (frame_acc) begin
			if (take_pending) begin
				pending_high_byte_q <= frame_byte;
			end
			if (at_last) begin
				byte_position_q <= '0;
				running_sum_q   <= '0;
				header_good_q   <= 1'b1;
			end else begin
				byte_position_q <= pos + 5'd1;
				running_sum_q   <= sum_next;
				header_good_q   <= hdr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write_shadow) begin
			shadow_q[shadow_idx] <= {pending_high_byte_q, frame_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_READINGS; i++) begin
				committed_q[i] <= '0;
			end
		end else if (commit) begin
			for (int i = 0; i < NUM_READINGS; i++) begin
				committed_q[i] <= shadow_q[i];
			end
		end
	end

	psfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

	assign status          = out_data.status;
	assign reading         = out_data.reading;
	assign is_frame_result = out_data.is_frame_result;

	`PSFP_ASSERT_SAME(a_stall_needs_result, in_stall, out_valid)
	`PSFP_ASSERT_SAME(a_frame_reading_zero, out_valid && is_frame_result, reading == 16'd0)
	`PSFP_ASSERT_SAME(a_frame_not_unsup, out_valid && is_frame_result,
		status != STATUS_UNSUPPORTED)
	`PSFP_ASSERT_NEXT(a_wrap_after_last, frame_acc && at_last,
		byte_position_q == 5'd0 && running_sum_q == 16'd0 && header_good_q)

endmodule
